FILE: hdl/mf_pkg.sv
// shared types and constants for the 3x3 median filter
package mf_pkg;

  localparam int CFG_BITS  = 12;
  localparam int PORT_BITS = 16;
  localparam int ROW_BITS  = 13;
  localparam int IDX_BITS  = 8;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 8'd0,
    REG_IMAGE_HEIGHT = 8'd1
  } cfg_reg_t;

  // per-word control decided at the front
  typedef struct packed {
    logic emit;
    logic mask_top;
    logic mask_bot;
    logic mask_left;
    logic mask_right;
    logic last;
  } item_ctrl_t;

endpackage

FILE: hdl/median_filter_3x3.sv
// 3x3 zero-padded median filter, top level
// throughput: one word per cycle while neither side stalls; a stalled result side backs up to the input
// path from taking the word that completes a window to its result showing:
//   line store read, item queue, issue register, 3 median stages, result queue
// the completing word arrives width+1 positions after the centre pixel
// reset: rst clears counters, queues and config (640 x 480); line stores keep old contents
module median_filter_3x3 import mf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 16,
  parameter int IDEPTH     = 4,
  parameter int ODEPTH     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [PORT_BITS-1:0] pixel_in,
  input  logic                 drain,
  output logic                 empty,
  input  logic                 pop,
  output logic [PORT_BITS-1:0] median_out,
  output logic                 frame_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data
);

  localparam int QW = 3 * PIXEL_BITS + $bits(item_ctrl_t);
  localparam int RW = PIXEL_BITS + 1;

  logic                       q_push;
  logic [QW-1:0]              q_wdata;
  logic [QW-1:0]              q_rdata;
  logic                       q_pop;
  logic                       q_empty;
  logic                       q_full;
  logic                       m_valid;
  logic [8:0][PIXEL_BITS-1:0] m_win;
  logic                       m_last;
  logic                       med_valid;
  logic [PIXEL_BITS-1:0]      med;
  logic                       med_last;
  logic                       res_pop;
  logic [RW-1:0]              res_word;
  logic                       res_full;

  mf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .IDEPTH     (IDEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel_in  (pixel_in),
    .drain     (drain),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_pop     (q_pop)
  );

  mf_fifo #(
    .DEPTH (IDEPTH),
    .WIDTH (QW)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  mf_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .ODEPTH     (ODEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .res_pop (res_pop),
    .m_valid (m_valid),
    .m_win   (m_win),
    .m_last  (m_last)
  );

  mf_median #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_win    (m_win),
    .in_last   (m_last),
    .out_valid (med_valid),
    .out_med   (med),
    .out_last  (med_last)
  );

  assign res_pop = pop && !empty;

  mf_fifo #(
    .DEPTH (ODEPTH),
    .WIDTH (RW)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (med_valid),
    .wdata ({med_last, med}),
    .pop   (res_pop),
    .rdata (res_word),
    .empty (empty),
    .full  (res_full)
  );

  assign median_out = PORT_BITS'(res_word[PIXEL_BITS-1:0]);
  assign frame_last = res_word[RW-1];

  a_res_room: assert property (@(posedge clk) disable iff (rst)
      med_valid |-> !res_full || res_pop)
    else $error("median result with no room in result queue");
  a_item_room: assert property (@(posedge clk) disable iff (rst)
      q_push |-> !q_full || q_pop)
    else $error("front word with no room in item queue");

endmodule

FILE: hdl/mf_fifo.sv
// small register-based queue used between the filter stages
module mf_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

FILE: hdl/mf_front.sv
// front end: raster counters, line stores and per-word classification
module mf_front import mf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 16,
  parameter int IDEPTH     = 4
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      push,
  output logic                                      full,
  input  logic [PORT_BITS-1:0]                      pixel_in,
  input  logic                                      drain,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [IDX_BITS-1:0]                       cfg_index,
  input  logic [CFG_BITS-1:0]                       cfg_data,
  output logic                                      q_push,
  output logic [3*PIXEL_BITS+$bits(item_ctrl_t)-1:0] q_data,
  input  logic                                      q_pop
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int XB = (WB > CFG_BITS) ? WB : CFG_BITS;
  localparam int UB = $clog2(IDEPTH + 1);

  logic [CFG_BITS-1:0]   image_width;
  logic [CFG_BITS-1:0]   image_height;
  logic [AW-1:0]         col;
  logic [ROW_BITS-1:0]   row;
  logic [UB-1:0]         used;

  logic                  accept;
  logic                  cfg_hit;
  logic                  row_start;
  logic [XB-1:0]         width_x;
  logic [WB-1:0]         wd;
  logic [ROW_BITS-1:0]   ht;
  logic [WB-1:0]         col_inc;
  logic                  wrap;
  item_ctrl_t            ctrl;
  logic [PIXEL_BITS-1:0] pix;

  logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] up_rd;
  logic [PIXEL_BITS-1:0] mid_rd;

  logic                  s1_valid;
  logic [AW-1:0]         s1_col;
  logic [PIXEL_BITS-1:0] s1_pix;
  item_ctrl_t            s1_ctrl;

  assign full      = (used == UB'(IDEPTH));
  assign accept    = push && !full;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // width in use is held to 2..MAX_WIDTH, height zero counts as one row
  assign width_x = XB'(image_width);
  always_comb begin
    if (width_x < XB'(2)) begin
      wd = WB'(2);
    end else if (width_x > XB'(MAX_WIDTH)) begin
      wd = WB'(MAX_WIDTH);
    end else begin
      wd = WB'(width_x);
    end
    ht = (image_height == '0) ? ROW_BITS'(1) : ROW_BITS'(image_height);
  end

  assign pix     = drain ? '0 : pixel_in[PIXEL_BITS-1:0];
  assign col_inc = WB'(col) + WB'(1);
  assign wrap    = (col_inc >= wd);

  // a row-start word finishes the last pixel of the row two above (right column off frame),
  // any other word finishes the pixel up and to the left of it
  always_comb begin
    row_start       = (col == '0);
    ctrl.emit       = row_start ? (row > ROW_BITS'(1)) : (row != '0);
    ctrl.mask_top   = row_start ? (row == ROW_BITS'(2)) : (row == ROW_BITS'(1));
    ctrl.mask_bot   = row_start ? (row > ht) : (row >= ht);
    ctrl.mask_left  = !row_start && (col == AW'(1));
    ctrl.mask_right = row_start;
    ctrl.last       = row_start && (row > ht);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
        end
        default: begin
        end
      endcase
      if (cfg_hit) begin
        col <= '0;
        row <= '0;
      end
    end else if (accept) begin
      if (ctrl.last) begin
        col <= '0;
        row <= '0;
      end else if (wrap) begin
        col <= '0;
        row <= row + ROW_BITS'(1);
      end else begin
        col <= AW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + UB'(accept) - UB'(q_pop);
    end
  end

  // middle store: read old, write new pixel in the same cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd          <= middle_mem[col];
      middle_mem[col] <= pix;
    end
  end

  // upper store takes the middle row's old value in the cycle after the read
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd <= upper_mem[col];
    end
    if (s1_valid) begin
      upper_mem[s1_col] <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= col;
      s1_pix  <= pix;
      s1_ctrl <= ctrl;
    end
  end

  assign q_push = s1_valid;
  assign q_data = {up_rd, mid_rd, s1_pix, s1_ctrl};

  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= UB'(IDEPTH))
    else $error("front occupancy beyond queue depth");
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
      accept && ctrl.last && !cfg_valid |=> (col == '0 && row == '0))
    else $error("counters not cleared after last word of frame");

endmodule

FILE: hdl/mf_median.sv
// pipelined median-of-nine: sort rows, reduce columns, median of three
module mf_median #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [8:0][PIXEL_BITS-1:0] in_win,
  input  logic                       in_last,
  output logic                       out_valid,
  output logic [PIXEL_BITS-1:0]      out_med,
  output logic                       out_last
);

  // [2] max, [1] median, [0] min; the three compares run side by side
  function automatic logic [2:0][PIXEL_BITS-1:0] sort3(input logic [PIXEL_BITS-1:0] a,
                                                       input logic [PIXEL_BITS-1:0] b,
                                                       input logic [PIXEL_BITS-1:0] c);
    logic ab;
    logic bc;
    logic ac;
    logic [2:0][PIXEL_BITS-1:0] r;
    ab = (a > b);
    bc = (b > c);
    ac = (a > c);
    r[2] = (ab && ac) ? a : ((!ab && bc) ? b : c);
    r[0] = (!ab && !ac) ? a : ((ab && !bc) ? b : c);
    r[1] = (ab != ac) ? a : ((ab == bc) ? b : c);
    return r;
  endfunction

  logic [2:0][2:0][PIXEL_BITS-1:0] rows;
  logic                            v1;
  logic                            last1;
  logic [2:0][PIXEL_BITS-1:0]      lows_s;
  logic [2:0][PIXEL_BITS-1:0]      mids_s;
  logic [2:0][PIXEL_BITS-1:0]      highs_s;
  logic [2:0][PIXEL_BITS-1:0]      trio;
  logic                            v2;
  logic                            last2;
  logic [2:0][PIXEL_BITS-1:0]      fin_s;

  always_ff @(posedge clk) begin
    if (in_valid) begin
      for (int r = 0; r < 3; r++) begin
        rows[r] <= sort3(in_win[3*r], in_win[3*r+1], in_win[3*r+2]);
      end
      last1 <= in_last;
    end
  end

  always_comb begin
    lows_s  = sort3(rows[0][0], rows[1][0], rows[2][0]);
    mids_s  = sort3(rows[0][1], rows[1][1], rows[2][1]);
    highs_s = sort3(rows[0][2], rows[1][2], rows[2][2]);
    fin_s   = sort3(trio[0], trio[1], trio[2]);
  end

  // max of lows, median of medians, min of highs
  always_ff @(posedge clk) begin
    if (v1) begin
      trio[0] <= lows_s[2];
      trio[1] <= mids_s[1];
      trio[2] <= highs_s[0];
      last2   <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      out_med  <= fin_s[1];
      out_last <= last2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

FILE: hdl/mf_back.sv
// back end: window shift, edge masking and issue into the median pipeline
module mf_back import mf_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int ODEPTH     = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_empty,
  input  logic [3*PIXEL_BITS+$bits(item_ctrl_t)-1:0] q_data,
  output logic                                      q_pop,
  input  logic                                      res_pop,
  output logic                                      m_valid,
  output logic [8:0][PIXEL_BITS-1:0]                m_win,
  output logic                                      m_last
);

  localparam int CTRL_BITS = $bits(item_ctrl_t);
  localparam int QW        = 3 * PIXEL_BITS + CTRL_BITS;
  localparam int CB        = $clog2(ODEPTH + 1);

  logic [PIXEL_BITS-1:0]      h_up;
  logic [PIXEL_BITS-1:0]      h_mid;
  logic [PIXEL_BITS-1:0]      h_pix;
  item_ctrl_t                 h_ctrl;
  logic [8:0][PIXEL_BITS-1:0] win;
  logic [8:0][PIXEL_BITS-1:0] win_next;
  logic [8:0][PIXEL_BITS-1:0] masked;
  logic [CB-1:0]              credit;
  logic                       issue_emit;

  assign h_up   = q_data[QW-1 -: PIXEL_BITS];
  assign h_mid  = q_data[QW-PIXEL_BITS-1 -: PIXEL_BITS];
  assign h_pix  = q_data[CTRL_BITS+PIXEL_BITS-1 -: PIXEL_BITS];
  assign h_ctrl = item_ctrl_t'(q_data[CTRL_BITS-1:0]);

  // credit covers words in the median pipeline and the result queue
  assign q_pop      = !q_empty && (!h_ctrl.emit || credit != CB'(ODEPTH));
  assign issue_emit = q_pop && h_ctrl.emit;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[3*r]   = win[3*r+1];
      win_next[3*r+1] = win[3*r+2];
    end
    win_next[2] = h_up;
    win_next[5] = h_mid;
    win_next[8] = h_pix;

    masked = win_next;
    for (int i = 0; i < 3; i++) begin
      if (h_ctrl.mask_top) begin
        masked[i] = '0;
      end
      if (h_ctrl.mask_bot) begin
        masked[6+i] = '0;
      end
      if (h_ctrl.mask_left) begin
        masked[3*i] = '0;
      end
      if (h_ctrl.mask_right) begin
        masked[3*i+2] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      win    <= win_next;
      m_win  <= masked;
      m_last <= h_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      credit  <= '0;
    end else begin
      m_valid <= issue_emit;
      credit  <= credit + CB'(issue_emit) - CB'(res_pop);
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst) credit <= CB'(ODEPTH))
    else $error("more results in flight than result queue slots");
  a_pop_has_credit: assert property (@(posedge clk) disable iff (rst)
      res_pop |-> credit != '0)
    else $error("result word taken with nothing issued");

endmodule

FILE: tb/median_filter_3x3_tb.sv
`timescale 1ns / 100ps
// testbench for the 3x3 zero-padded median filter
module median_filter_3x3_tb;
  import mf_pkg::*;

  localparam int LINE_DEPTH    = 2048;
  localparam int LINE_BITS     = $clog2(LINE_DEPTH);
  localparam int GAP_MAX       = 18;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 1000;
  localparam int WHOLE_FRAME   = 32'h7fff_ffff;

  typedef logic [8:0][PORT_BITS-1:0] window_t;

  typedef struct packed {
    logic [PORT_BITS-1:0] median;
    logic                 last;
  } median_word_t;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_NOISY,
    FRAME_NO_DRAIN,
    FRAME_CUT
  } frame_kind_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [PORT_BITS-1:0] pixel_in;
  logic                 drain;
  logic                 empty;
  logic                 pop;
  logic [PORT_BITS-1:0] median_out;
  logic                 frame_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_BITS-1:0]  cfg_index;
  logic [CFG_BITS-1:0]  cfg_data;

  // filter model state
  logic [CFG_BITS-1:0]  width_reg;
  logic [CFG_BITS-1:0]  height_reg;
  logic [PORT_BITS-1:0] upper_line [LINE_DEPTH];
  logic [PORT_BITS-1:0] middle_line [LINE_DEPTH];
  window_t              window;
  int unsigned          col_pos;
  int unsigned          row_pos;
  median_word_t         median_due [$];
  median_word_t         want;

  int send_gap_max;
  int take_gap_max;
  int take_gap;
  int take_wait = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int words_sent = 0;
  int medians_checked = 0;
  int frames_done = 0;

  always #10 clk = ~clk;

  median_filter_3x3 DUT (.*);

  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    window  = '0;
  endfunction

  // zero the taps outside the frame, then pick the fifth smallest
  function automatic logic [PORT_BITS-1:0] median_of(window_t w, int unsigned cr,
                                                     int unsigned cc, int unsigned wd,
                                                     int unsigned ht);
    logic [PORT_BITS-1:0] t;
    int i;
    int j;
    for (i = 0; i < 3; i++) begin
      if (cr == 0) w[i] = '0;
      if (cr + 1 >= ht) w[6 + i] = '0;
      if (cc == 0) w[i * 3] = '0;
      if (cc + 1 >= wd) w[i * 3 + 2] = '0;
    end
    for (i = 0; i < 8; i++) begin
      for (j = 0; j < 8 - i; j++) begin
        if (w[j] > w[j + 1]) begin
          t        = w[j];
          w[j]     = w[j + 1];
          w[j + 1] = t;
        end
      end
    end
    return w[4];
  endfunction

  // advance the filter by one accepted word, queue the median it completes
  function automatic void filter_word(logic [PORT_BITS-1:0] value, logic is_drain);
    int unsigned wd;
    int unsigned ht;
    int unsigned ic;
    int unsigned ir;
    int unsigned cr;
    int unsigned cc;
    int r;
    logic [LINE_BITS-1:0] ci;
    logic [PORT_BITS-1:0] pix;
    logic [PORT_BITS-1:0] up;
    logic [PORT_BITS-1:0] mid;
    window_t w;
    logic hit;
    median_word_t res;
    wd  = eff_width();
    ht  = eff_height();
    ic  = col_pos;
    ir  = row_pos;
    pix = is_drain ? '0 : value;
    hit = 1'b0;
    cr  = 0;
    cc  = 0;
    res = '0;
    if (ic >= wd) ic = 0;
    ci = LINE_BITS'(ic);
    // first word of a row closes the last pixel of the row two above with a zero column
    if (ic == 0 && ir >= 2) begin
      for (r = 0; r < 3; r++) begin
        w[r * 3]     = window[r * 3 + 1];
        w[r * 3 + 1] = window[r * 3 + 2];
        w[r * 3 + 2] = '0;
      end
      cr  = ir - 2;
      cc  = wd - 1;
      hit = 1'b1;
      res.median = median_of(w, cr, cc, wd, ht);
    end
    up  = upper_line[ci];
    mid = middle_line[ci];
    upper_line[ci]  = mid;
    middle_line[ci] = pix;
    for (r = 0; r < 3; r++) begin
      window[r * 3]     = window[r * 3 + 1];
      window[r * 3 + 1] = window[r * 3 + 2];
    end
    window[2] = up;
    window[5] = mid;
    window[8] = pix;
    if (ic >= 1 && ir >= 1) begin
      cr  = ir - 1;
      cc  = ic - 1;
      hit = 1'b1;
      res.median = median_of(window, cr, cc, wd, ht);
    end
    ic++;
    if (ic >= wd) begin
      ic = 0;
      ir++;
    end
    col_pos = ic;
    row_pos = ir;
    if (hit) begin
      res.last = (cr + 1 >= ht) && (cc + 1 >= wd);
      median_due.push_back(res);
      if (res.last) begin
        col_pos = 0;
        row_pos = 0;
        frames_done++;
      end
    end
  endfunction

  function automatic logic [PORT_BITS-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return PORT_BITS'($urandom_range(0, 3));  // small values give ties in the window
      default: return PORT_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_word(input logic [PORT_BITS-1:0] value, input logic is_drain);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    pixel_in <= value;
    drain    <= is_drain;
    @(posedge clk);
    while (full) @(posedge clk);
    filter_word(value, is_drain);
    words_sent++;
  endtask

  task automatic pause_for_results();
    push <= 1'b0;
    while (median_due.size() != 0) @(posedge clk);
  endtask

  // words that make no median may still be in flight after the last result
  task automatic wait_idle();
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = w;
    restart_frame();
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    height_reg = h;
    restart_frame();
  endtask

  task automatic send_frame(input frame_kind_t kind, input int max_words);
    int body;
    int total;
    int k;
    logic is_drain;
    body  = eff_width() * eff_height();
    total = body + eff_width() + 1;
    for (k = 0; k < total && k < max_words; k++) begin
      case (kind)
        FRAME_NOISY:    is_drain = ($urandom_range(0, 3) == 0);
        FRAME_NO_DRAIN: is_drain = 1'b0;
        default:        is_drain = (k >= body);
      endcase
      send_word(random_pixel(), is_drain);
    end
  endtask

  // default 640 x 480 straight out of reset, part of the second row
  task automatic test_reset_values();
    int k;
    send_gap_max = GAP_MAX;
    take_gap_max = GAP_MAX;
    for (k = 0; k < 700; k++) send_word(random_pixel(), 1'b0);
    wait_idle();
  endtask

  task automatic test_small_frames();
    set_frame(12'd3, 12'd3);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b1);  // drain inside the frame reads as zero
    send_word(16'h8000, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFE, 1'b0);
    send_word(16'h1234, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b0);  // pixel in the last drain slot
    wait_idle();
    // width below range clamps to 2, height 0 runs as one row
    set_frame(12'd1, 12'd0);
    send_frame(FRAME_CLEAN, WHOLE_FRAME);
    pause_for_results();
    send_frame(FRAME_CLEAN, WHOLE_FRAME);
    wait_idle();
  endtask

  task automatic test_size_limits();
    send_gap_max = 0;
    take_gap_max = 0;
    // tallest frame, cut after the first rows
    set_frame(12'd2, 12'd4095);
    send_frame(FRAME_CLEAN, 200);
    wait_idle();
    // one long row, bottom and top masked together
    set_frame(12'd40, 12'd1);
    send_frame(FRAME_CLEAN, WHOLE_FRAME);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int start;
    int frames;
    int f;
    int mode;
    int pick;
    logic [CFG_BITS-1:0] w;
    logic [CFG_BITS-1:0] h;
    frame_kind_t kind;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      mode = $urandom_range(0, 5);
      send_gap_max = (mode <= 1) ? 0 : GAP_MAX;
      take_gap_max = (mode == 0 || mode == 2) ? 0 : GAP_MAX;
      case ($urandom_range(0, 19))
        0:       w = CFG_BITS'($urandom_range(0, 1));
        1, 2, 3: w = CFG_BITS'($urandom_range(11, 40));
        default: w = CFG_BITS'($urandom_range(2, 10));
      endcase
      case ($urandom_range(0, 19))
        0:       h = '0;
        1, 2:    h = CFG_BITS'($urandom_range(7, 16));
        default: h = CFG_BITS'($urandom_range(1, 6));
      endcase
      wait_idle();
      set_frame(w, h);
      frames = $urandom_range(1, 4);
      for (f = 0; f < frames; f++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      kind = FRAME_CLEAN;
        else if (pick < 8) kind = FRAME_NOISY;
        else if (pick < 9) kind = FRAME_NO_DRAIN;
        else               kind = FRAME_CUT;
        if (kind == FRAME_CUT) begin
          // stop mid frame; the next register write restarts it
          send_frame(kind, $urandom_range(1, eff_width() * eff_height() + eff_width()));
          break;
        end
        send_frame(kind, WHOLE_FRAME);
        if ($urandom_range(0, 7) == 0) pause_for_results();
      end
    end
  endtask

  // result side: random stalls between words
  always @(posedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      take_wait <= 0;
    end else if (pop && !empty) begin
      take_gap = $urandom_range(0, take_gap_max);
      take_wait <= take_gap;
      pop       <= (take_gap == 0);
    end else if (take_wait > 0) begin
      take_wait <= take_wait - 1;
      pop       <= (take_wait == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (median_due.size() == 0) begin
        $error("word with none expected: median_out=%0d frame_last=%0b",
               median_out, frame_last);
        fail_count++;
      end else begin
        want = median_due.pop_front();
        medians_checked++;
        if (median_out !== want.median) begin
          $error("median_out: expected %0d, got %0d", want.median, median_out);
          fail_count++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, frame_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("median_filter_3x3 test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    pixel_in  <= '0;
    drain     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_frame();
    upper_line  = '{default: '0};
    middle_line = '{default: '0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_small_frames();
    test_size_limits();
    test_random_frames();
    wait_idle();
    $display("sent %0d words over %0d finished frames, widths 2 to 640, heights 1 to 4095",
             words_sent, frames_done);
    $display("checked %0d medians with random stalls on both sides", medians_checked);
    if (fail_count == 0) begin
      $display("median_filter_3x3 test passed");
    end else begin
      $display("median_filter_3x3 test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mf_pkg.sv
hdl/mf_fifo.sv
hdl/mf_front.sv
hdl/mf_median.sv
hdl/mf_back.sv
hdl/median_filter_3x3.sv
tb/median_filter_3x3_tb.sv
